// ----- hdl/cas_pkg.sv -----
// ---------------------------------------------------------------------------
// cas_pkg: shared types and constants of the CAN alive supervisor
// Event codes, register indexes, item record and the CRC-8 J1850 function.
// ---------------------------------------------------------------------------
package cas_pkg;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_ALIVE_OK = 4'd1,
    EV_CRC_FAIL = 4'd2,
    EV_LED_ON   = 4'd3,
    EV_LED_OFF  = 4'd4,
    EV_UNKNOWN  = 4'd5,
    EV_OTHER    = 4'd6,
    EV_EXTENDED = 4'd7,
    EV_TIMEOUT  = 4'd8
  } event_code_t;

  typedef enum logic [1:0] {
    REG_ALIVE_TIMEOUT = 2'd0,
    REG_ALIVE_ID      = 2'd1,
    REG_COMMAND_ID    = 2'd2,
    REG_NONE          = 2'd3
  } reg_index_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } operation_t;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd1500;
  localparam logic [10:0] ALIVE_ID_RESET = 11'h101;
  localparam logic [10:0] CMD_ID_RESET   = 11'h200;
  localparam logic [15:0] AGE_MAX        = 16'hFFFF;
  localparam logic [3:0]  ALIVE_DLC      = 4'd8;
  localparam logic [7:0]  CMD_LED_ON     = 8'h01;
  localparam logic [7:0]  CMD_LED_OFF    = 8'h00;
  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [7:0]  CRC_POLY       = 8'h1D;
  localparam int          CRC_BYTES      = 7;
  localparam int          CRC_BITS       = CRC_BYTES * 8;

  typedef struct packed {
    logic        operation;
    logic [10:0] frame_ident;
    logic        extended_flag;
    logic [3:0]  length_code;
    logic [CRC_BITS-1:0] data;   // byte0 in the top byte, byte6 in the bottom byte
    logic [7:0]  byte7;
  } item_t;

  // raw CRC register after shifting in data, MSB first, no final inversion
  function automatic logic [7:0] crc_raw(input logic [7:0] init,
                                         input logic [CRC_BITS-1:0] data);
    logic [7:0] c;
    c = init;
    for (int i = 0; i < CRC_BYTES; i++) begin
      c = c ^ data[CRC_BITS-1-8*i -: 8];
      for (int b = 0; b < 8; b++) begin
        c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/cas_if.sv -----
// ---------------------------------------------------------------------------
// cas_if: channel interfaces of the CAN alive supervisor
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
interface cas_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [10:0] frame_ident;
  logic        extended_flag;
  logic [3:0]  length_code;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic [7:0]  byte6;
  logic [7:0]  byte7;

  modport source (output valid, operation, frame_ident, extended_flag, length_code,
                  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
                  input ready);
  modport sink (input valid, operation, frame_ident, extended_flag, length_code,
                byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
                output ready);
endinterface

interface cas_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic [7:0] computed_crc;
  logic       led_level;
  logic       peer_lost;

  modport source (output valid, event_code, computed_crc, led_level, peer_lost,
                  input ready);
  modport sink (input valid, event_code, computed_crc, led_level, peer_lost,
                output ready);
endinterface

interface cas_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/can_alive_supervisor_crc8.sv -----
// ---------------------------------------------------------------------------
// can_alive_supervisor_crc8: CAN alive supervisor with CRC-8 J1850 check
// Checks alive frames, decodes LED commands and times out the peer on ticks.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   operation, frame_ident, extended_flag,
//                               length_code, byte0..byte7
//   out_ch   out  valid/ready   event_code, computed_crc, led_level, peer_lost
//   cfg_ch   in   valid/ready   index, data (cfg_ch.ready always high)
//
// One item per cycle while out_ch is not stalled; each item passes the input register, then the result register.
// CRC, compares and the age increment sit between those two registers.
// Reset is synchronous: pipeline empty, registers to defaults, peer lost.
// A stalled result holds the result register; the input register still
// accepts one more item, then in_ch.ready drops until the result is taken.
// ---------------------------------------------------------------------------
module can_alive_supervisor_crc8 (
  input  logic        clk,
  input  logic        rst_n,
  cas_in_if.sink      in_ch,
  cas_out_if.source   out_ch,
  cas_cfg_if.sink     cfg_ch
);

  logic                s1_valid_r;
  cas_pkg::item_t      s1_item_r;
  logic                s1_fire;

  logic                out_valid_r;
  cas_pkg::event_code_t out_event_r;
  logic [7:0]          out_crc_r;

  logic [15:0]         timeout_r;
  logic [10:0]         alive_id_r;
  logic [10:0]         cmd_id_r;

  logic [15:0]         age_r, age_nxt;
  logic                lost_r, lost_nxt;
  logic                led_r, led_nxt;
  cas_pkg::event_code_t event_nxt;
  logic [7:0]          crc;
  logic [15:0]         age_inc;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{operation:     in_ch.operation,
                     frame_ident:   in_ch.frame_ident,
                     extended_flag: in_ch.extended_flag,
                     length_code:   in_ch.length_code,
                     data:          {in_ch.byte0, in_ch.byte1, in_ch.byte2, in_ch.byte3,
                                     in_ch.byte4, in_ch.byte5, in_ch.byte6},
                     byte7:         in_ch.byte7};
    end
  end

  cas_crc8 u_crc (
    .data_i (s1_item_r.data),
    .crc_o  (crc)
  );

  assign age_inc = (age_r == cas_pkg::AGE_MAX) ? age_r : age_r + 16'd1;

  always_comb begin
    age_nxt   = age_r;
    lost_nxt  = lost_r;
    led_nxt   = led_r;
    event_nxt = cas_pkg::EV_NONE;
    if (s1_item_r.operation == cas_pkg::OP_TICK) begin
      age_nxt = age_inc;
      if (!lost_r && (age_inc > timeout_r)) begin
        lost_nxt  = 1'b1;
        event_nxt = cas_pkg::EV_TIMEOUT;
      end
    end else begin
      priority if (s1_item_r.extended_flag) begin
        event_nxt = cas_pkg::EV_EXTENDED;
      end else if ((s1_item_r.frame_ident == alive_id_r) &&
                   (s1_item_r.length_code == cas_pkg::ALIVE_DLC)) begin
        if (s1_item_r.byte7 == crc) begin
          age_nxt   = 16'd0;
          lost_nxt  = 1'b0;
          event_nxt = cas_pkg::EV_ALIVE_OK;
        end else begin
          event_nxt = cas_pkg::EV_CRC_FAIL;
        end
      end else if ((s1_item_r.frame_ident == cmd_id_r) &&
                   (s1_item_r.length_code != 4'd0)) begin
        priority if (s1_item_r.data[cas_pkg::CRC_BITS-1 -: 8] == cas_pkg::CMD_LED_ON) begin
          led_nxt   = 1'b1;
          event_nxt = cas_pkg::EV_LED_ON;
        end else if (s1_item_r.data[cas_pkg::CRC_BITS-1 -: 8] == cas_pkg::CMD_LED_OFF) begin
          led_nxt   = 1'b0;
          event_nxt = cas_pkg::EV_LED_OFF;
        end else begin
          event_nxt = cas_pkg::EV_UNKNOWN;
        end
      end else begin
        event_nxt = cas_pkg::EV_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      age_r       <= 16'd0;
      lost_r      <= 1'b1;
      led_r       <= 1'b0;
    end else begin
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        age_r       <= age_nxt;
        lost_r      <= lost_nxt;
        led_r       <= led_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event_r <= event_nxt;
      out_crc_r   <= (s1_item_r.operation == cas_pkg::OP_TICK) ? 8'h00 : crc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= cas_pkg::TIMEOUT_RESET;
      alive_id_r <= cas_pkg::ALIVE_ID_RESET;
      cmd_id_r   <= cas_pkg::CMD_ID_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cas_pkg::reg_index_t'(cfg_ch.index))
        cas_pkg::REG_ALIVE_TIMEOUT: timeout_r  <= cfg_ch.data;
        cas_pkg::REG_ALIVE_ID:      alive_id_r <= cfg_ch.data[10:0];
        cas_pkg::REG_COMMAND_ID:    cmd_id_r   <= cfg_ch.data[10:0];
        default: ;
      endcase
    end
  end

  // level fields follow the state that the shown result left behind
  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_code   = out_event_r;
  assign out_ch.computed_crc = out_crc_r;
  assign out_ch.led_level    = led_r;
  assign out_ch.peer_lost    = lost_r;

endmodule

// ----- hdl/cas_crc8.sv -----
// ---------------------------------------------------------------------------
// cas_crc8: CRC-8 SAE J1850 over payload bytes 0 to 6
// Linear form: constant for the init value XOR one column per set data bit.
// ---------------------------------------------------------------------------
module cas_crc8 (
  input  logic [cas_pkg::CRC_BITS-1:0] data_i,
  output logic [7:0]                   crc_o
);

  localparam logic [7:0] CRC_ZERO =
    cas_pkg::crc_raw(cas_pkg::CRC_INIT, {cas_pkg::CRC_BITS{1'b0}});

  logic [7:0] terms [cas_pkg::CRC_BITS];

  for (genvar k = 0; k < cas_pkg::CRC_BITS; k++) begin : g_col
    localparam logic [7:0] COL =
      cas_pkg::crc_raw(8'h00, {{(cas_pkg::CRC_BITS-1){1'b0}}, 1'b1} << k);
    assign terms[k] = data_i[k] ? COL : 8'h00;
  end

  always_comb begin
    logic [7:0] acc;
    acc = CRC_ZERO;
    for (int k = 0; k < cas_pkg::CRC_BITS; k++) begin
      acc = acc ^ terms[k];
    end
    crc_o = ~acc;
  end

endmodule

// ----- hdl/cas_checker.sv -----
// ---------------------------------------------------------------------------
// cas_checker: port-level checks of the CAN alive supervisor
// Result consistency and output stall behavior, bound to the top level.
// ---------------------------------------------------------------------------
module cas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] event_code,
  input logic [7:0] computed_crc,
  input logic       led_level,
  input logic       peer_lost
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(event_code) && $stable(computed_crc) &&
      $stable(led_level) && $stable(peer_lost))
    else $error("stalled result changed");

  a_tick_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == cas_pkg::EV_NONE || event_code == cas_pkg::EV_TIMEOUT)
      |-> computed_crc == 8'h00)
    else $error("tick result carries a CRC");

  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == cas_pkg::EV_LED_ON || event_code == cas_pkg::EV_LED_OFF)
      |-> led_level == (event_code == cas_pkg::EV_LED_ON))
    else $error("LED level disagrees with command");

  a_peer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_code == cas_pkg::EV_ALIVE_OK || event_code == cas_pkg::EV_TIMEOUT)
      |-> peer_lost == (event_code == cas_pkg::EV_TIMEOUT))
    else $error("peer status disagrees with event");

endmodule

bind can_alive_supervisor_crc8 cas_checker u_cas_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_code   (out_ch.event_code),
  .computed_crc (out_ch.computed_crc),
  .led_level    (out_ch.led_level),
  .peer_lost    (out_ch.peer_lost)
);

// ----- tb/tb_can_alive_supervisor_crc8.sv -----
// ---------------------------------------------------------------------------
// tb_can_alive_supervisor_crc8: self-checking bench of the CAN alive supervisor
// Directed and random frames and ticks under random source gaps and sink
// stalls. A scoreboard predicts every result item and compares it field by
// field with what the block returns, across several register settings.
// ---------------------------------------------------------------------------
module tb_can_alive_supervisor_crc8;

  typedef struct packed {
    cas_pkg::operation_t op;
    logic [10:0]         ident;
    logic                ext;
    logic [3:0]          dlc;
    logic [0:7][7:0]     payload;
  } can_item_t;

  typedef struct packed {
    cas_pkg::event_code_t ev;
    logic [7:0]           crc;
    logic                 led;
    logic                 lost;
  } supervisor_result_t;

  // CRC-8 SAE J1850 over payload bytes 0..6, final inversion
  function automatic logic [7:0] j1850_of(input logic [0:7][7:0] p);
    logic [7:0] c;
    c = cas_pkg::CRC_INIT;
    for (int i = 0; i < cas_pkg::CRC_BYTES; i++) begin
      c = c ^ p[i];
      for (int b = 0; b < 8; b++) begin
        if (c[7]) begin
          c = {c[6:0], 1'b0} ^ cas_pkg::CRC_POLY;
        end else begin
          c = {c[6:0], 1'b0};
        end
      end
    end
    return ~c;
  endfunction

  class alive_scoreboard;
    logic [15:0] limit_ticks;
    logic [10:0] alive_id;
    logic [10:0] cmd_id;
    logic [15:0] age;
    logic        lost;
    logic        led;
    supervisor_result_t expected_q[$];
    int unsigned errors;

    function new();
      limit_ticks = cas_pkg::TIMEOUT_RESET;
      alive_id    = cas_pkg::ALIVE_ID_RESET;
      cmd_id      = cas_pkg::CMD_ID_RESET;
      age         = '0;
      lost        = 1'b1;
      led         = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(input cas_pkg::reg_index_t idx, input logic [15:0] value);
      case (idx)
        cas_pkg::REG_ALIVE_TIMEOUT: limit_ticks = value;
        cas_pkg::REG_ALIVE_ID:      alive_id = value[10:0];
        cas_pkg::REG_COMMAND_ID:    cmd_id = value[10:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(input can_item_t it);
      supervisor_result_t r;
      r.ev  = cas_pkg::EV_NONE;
      r.crc = '0;
      if (it.op == cas_pkg::OP_TICK) begin
        if (age != cas_pkg::AGE_MAX) age = age + 16'd1;
        if (!lost && age > limit_ticks) begin
          lost = 1'b1;
          r.ev = cas_pkg::EV_TIMEOUT;
        end
      end else begin
        r.crc = j1850_of(it.payload);
        if (it.ext) begin
          r.ev = cas_pkg::EV_EXTENDED;
        end else if (it.ident == alive_id && it.dlc == cas_pkg::ALIVE_DLC) begin
          if (it.payload[7] == r.crc) begin
            age  = '0;
            lost = 1'b0;
            r.ev = cas_pkg::EV_ALIVE_OK;
          end else begin
            r.ev = cas_pkg::EV_CRC_FAIL;
          end
        end else if (it.ident == cmd_id && it.dlc != 4'd0) begin
          if (it.payload[0] == cas_pkg::CMD_LED_ON) begin
            led  = 1'b1;
            r.ev = cas_pkg::EV_LED_ON;
          end else if (it.payload[0] == cas_pkg::CMD_LED_OFF) begin
            led  = 1'b0;
            r.ev = cas_pkg::EV_LED_OFF;
          end else begin
            r.ev = cas_pkg::EV_UNKNOWN;
          end
        end else begin
          r.ev = cas_pkg::EV_OTHER;
        end
      end
      r.led  = led;
      r.lost = lost;
      expected_q.push_back(r);
    endfunction

    function void check_result(input logic [3:0] ev, input logic [7:0] crc,
                               input logic led_lvl, input logic lost_lvl);
      supervisor_result_t e;
      if (expected_q.size() == 0) begin
        $error("result item with nothing pending: event_code %0d", ev);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (ev !== e.ev) begin
        $error("event_code: expected %0d, got %0d", e.ev, ev);
        errors++;
      end
      if (crc !== e.crc) begin
        $error("computed_crc: expected 0x%02h, got 0x%02h", e.crc, crc);
        errors++;
      end
      if (led_lvl !== e.led) begin
        $error("led_level: expected %0b, got %0b", e.led, led_lvl);
        errors++;
      end
      if (lost_lvl !== e.lost) begin
        $error("peer_lost: expected %0b, got %0b", e.lost, lost_lvl);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on = 1'b1;
  alive_scoreboard sb;

  cas_in_if  in_ch();
  cas_out_if out_ch();
  cas_cfg_if cfg_ch();

  can_alive_supervisor_crc8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic can_item_t mk(input cas_pkg::operation_t op, input logic [10:0] id,
                                   input logic ext, input logic [3:0] dlc,
                                   input logic [63:0] bytes, input bit fix_crc);
    can_item_t it;
    it.op      = op;
    it.ident   = id;
    it.ext     = ext;
    it.dlc     = dlc;
    it.payload = bytes;
    if (fix_crc) it.payload[7] = j1850_of(it.payload);
    return it;
  endfunction

  function automatic logic [63:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  function automatic can_item_t random_item();
    int unsigned pick;
    logic [3:0]  dlc;
    can_item_t   it;
    pick = $urandom_range(99);
    if (pick < 35) begin
      it = mk(cas_pkg::OP_TICK, 11'($urandom), 1'($urandom), 4'($urandom),
              rand_bytes(), 0);
    end else if (pick < 60) begin
      dlc = ($urandom_range(9) == 0) ? 4'($urandom) : cas_pkg::ALIVE_DLC;
      it = mk(cas_pkg::OP_FRAME, sb.alive_id, 1'b0, dlc, rand_bytes(),
              $urandom_range(9) < 8);
    end else if (pick < 78) begin
      it = mk(cas_pkg::OP_FRAME, sb.cmd_id, 1'b0, 4'($urandom), rand_bytes(), 0);
      case ($urandom_range(2))
        0: it.payload[0] = cas_pkg::CMD_LED_ON;
        1: it.payload[0] = cas_pkg::CMD_LED_OFF;
        default: ;
      endcase
    end else if (pick < 86) begin
      it = mk(cas_pkg::OP_FRAME, ($urandom_range(1) == 0) ? sb.alive_id : 11'($urandom),
              1'b1, 4'($urandom), rand_bytes(), 1'($urandom_range(1)));
    end else begin
      it = mk(cas_pkg::OP_FRAME, 11'($urandom), 1'($urandom), 4'($urandom),
              rand_bytes(), 0);
    end
    return it;
  endfunction

  task automatic send_item(input can_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.operation     <= it.op;
    in_ch.frame_ident   <= it.ident;
    in_ch.extended_flag <= it.ext;
    in_ch.length_code   <= it.dlc;
    in_ch.byte0         <= it.payload[0];
    in_ch.byte1         <= it.payload[1];
    in_ch.byte2         <= it.payload[2];
    in_ch.byte3         <= it.payload[3];
    in_ch.byte4         <= it.payload[4];
    in_ch.byte5         <= it.payload[5];
    in_ch.byte6         <= it.payload[6];
    in_ch.byte7         <= it.payload[7];
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cas_pkg::reg_index_t idx, input logic [15:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits of the id writes are random to exercise masking
  task automatic configure(input logic [15:0] limit, input logic [10:0] alive_id,
                           input logic [10:0] cmd_id);
    drain();
    write_reg(cas_pkg::REG_ALIVE_TIMEOUT, limit);
    write_reg(cas_pkg::REG_ALIVE_ID, {5'($urandom), alive_id});
    write_reg(cas_pkg::REG_COMMAND_ID, {5'($urandom), cmd_id});
    write_reg(cas_pkg::REG_NONE, 16'($urandom));
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_on = allow_idle && ($urandom_range(3) != 0);
      if ($urandom_range(149) == 0) drain();
      send_item(random_item());
    end
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(5) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.event_code, out_ch.computed_crc,
                      out_ch.led_level, out_ch.peer_lost);
    end
  end

  initial begin
    logic [10:0] same_id;
    sb = new();
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= cas_pkg::OP_FRAME;
    in_ch.frame_ident   <= '0;
    in_ch.extended_flag <= 1'b0;
    in_ch.length_code   <= '0;
    in_ch.byte0         <= '0;
    in_ch.byte1         <= '0;
    in_ch.byte2         <= '0;
    in_ch.byte3         <= '0;
    in_ch.byte4         <= '0;
    in_ch.byte5         <= '0;
    in_ch.byte6         <= '0;
    in_ch.byte7         <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= cas_pkg::REG_ALIVE_TIMEOUT;
    cfg_ch.data         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, every event, length code corners
    send_item(mk(cas_pkg::OP_TICK, 11'h000, 1'b0, 4'd0, 64'h0, 0));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::ALIVE_ID_RESET, 1'b0, cas_pkg::ALIVE_DLC,
                 64'h0, 1));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::ALIVE_ID_RESET, 1'b0, cas_pkg::ALIVE_DLC,
                 {64{1'b1}}, 0));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::CMD_ID_RESET, 1'b0, 4'd1,
                 {cas_pkg::CMD_LED_ON, 56'h0}, 0));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::CMD_ID_RESET, 1'b0, 4'd8,
                 {cas_pkg::CMD_LED_OFF, {56{1'b1}}}, 0));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::CMD_ID_RESET, 1'b0, 4'd15, {64{1'b1}}, 0));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::CMD_ID_RESET, 1'b0, 4'd0,
                 {cas_pkg::CMD_LED_ON, 56'h0}, 0));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::ALIVE_ID_RESET, 1'b1, cas_pkg::ALIVE_DLC,
                 rand_bytes(), 1));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::ALIVE_ID_RESET, 1'b0, 4'd7, rand_bytes(), 1));
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::ALIVE_ID_RESET, 1'b0, 4'd9, rand_bytes(), 1));
    send_item(mk(cas_pkg::OP_FRAME, 11'h7FF, 1'b0, cas_pkg::ALIVE_DLC, rand_bytes(), 1));
    send_item(mk(cas_pkg::OP_TICK, 11'h7FF, 1'b1, 4'd15, {64{1'b1}}, 0));
    configure(16'd2, cas_pkg::ALIVE_ID_RESET, cas_pkg::CMD_ID_RESET);
    repeat (3) send_item(mk(cas_pkg::OP_TICK, 11'h000, 1'b0, 4'd0, 64'h0, 0));
    // same id in both registers
    configure(16'd0, 11'h155, 11'h155);
    send_item(mk(cas_pkg::OP_FRAME, 11'h155, 1'b0, cas_pkg::ALIVE_DLC, rand_bytes(), 1));
    send_item(mk(cas_pkg::OP_FRAME, 11'h155, 1'b0, 4'd3, {cas_pkg::CMD_LED_ON, 56'h0}, 0));
    send_item(mk(cas_pkg::OP_FRAME, 11'h155, 1'b0, 4'd0, rand_bytes(), 0));
    send_item(mk(cas_pkg::OP_TICK, 11'h000, 1'b0, 4'd0, 64'h0, 0));
    send_item(mk(cas_pkg::OP_TICK, 11'h000, 1'b0, 4'd0, 64'h0, 0));
    send_item(mk(cas_pkg::OP_FRAME, 11'h155, 1'b1, 4'd3, {cas_pkg::CMD_LED_OFF, 56'h0}, 0));

    // limit at maximum, ticks back to back
    configure(cas_pkg::AGE_MAX, cas_pkg::ALIVE_ID_RESET, cas_pkg::CMD_ID_RESET);
    send_item(mk(cas_pkg::OP_FRAME, cas_pkg::ALIVE_ID_RESET, 1'b0, cas_pkg::ALIVE_DLC,
                 rand_bytes(), 1));
    idle_on = 1'b0;
    repeat (40) send_item(mk(cas_pkg::OP_TICK, 11'h000, 1'b0, 4'd0, 64'h0, 0));
    drain();
    write_reg(cas_pkg::REG_ALIVE_TIMEOUT, cas_pkg::AGE_MAX - 16'd1);
    send_item(mk(cas_pkg::OP_TICK, 11'h000, 1'b0, 4'd0, 64'h0, 0));
    idle_on = 1'b1;

    configure(cas_pkg::TIMEOUT_RESET, cas_pkg::ALIVE_ID_RESET, cas_pkg::CMD_ID_RESET);
    run_random(280, 1'b1);
    configure(16'd0, 11'h000, 11'h7FF);
    run_random(280, 1'b1);
    configure(16'($urandom_range(12, 1)), 11'($urandom), 11'($urandom));
    run_random(280, 1'b1);
    same_id = 11'($urandom);
    configure(16'($urandom_range(8, 2)), same_id, same_id);
    run_random(280, 1'b1);
    configure(cas_pkg::AGE_MAX, 11'h7FF, 11'h000);
    run_random(280, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** can_alive_supervisor_crc8: PASSED **");
    end else begin
      $display("** can_alive_supervisor_crc8: FAILED **");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("** can_alive_supervisor_crc8: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cas_pkg.sv
hdl/cas_if.sv
hdl/cas_crc8.sv
hdl/can_alive_supervisor_crc8.sv
hdl/cas_checker.sv
tb/tb_can_alive_supervisor_crc8.sv
